FILE: rtl/guid_text_parser_unit_defines.svh
// Assertion macros for the GUID text parser block.
`ifndef GUID_TEXT_PARSER_UNIT_DEFINES_SVH
`define GUID_TEXT_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GTP_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GTP_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);
`else
`define GTP_ASSERT_NOW(lbl, ant, con, msg)
`define GTP_ASSERT_NEXT(lbl, ant, con, msg)
`endif

`endif

FILE: rtl/gtp_pkg.sv
// Types, constants and the hex digit decoder shared by the GUID text parser.
package gtp_pkg;

	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_DASH = 8'h2d;

	localparam logic [5:0] UUID_LEN  = 6'd36;
	localparam logic [5:0] UUID_LAST = 6'd35;
	localparam logic [5:0] DASH_P0   = 6'd8;
	localparam logic [5:0] DASH_P1   = 6'd13;
	localparam logic [5:0] DASH_P2   = 6'd18;
	localparam logic [5:0] DASH_P3   = 6'd23;
	localparam logic [5:0] POS_MAX   = 6'd63;

	localparam logic [3:0] WORD_DIGITS = 4'd8;
	localparam logic [1:0] GROUP_LAST  = 2'd3;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [5:0]  position;
		logic [1:0]  group_index;
		word_t       accumulator;
		logic        group_empty;
		logic [3:0]  digits_in_group;
		logic        failed;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		position:        6'd0,
		group_index:     2'd0,
		accumulator:     32'd0,
		group_empty:     1'b1,
		digits_in_group: 4'd0,
		failed:          1'b0
	};

	typedef struct packed {
		logic       en;
		logic [1:0] idx;
	} word_wr_t;

	typedef struct packed {
		logic             ok;
		logic [3:0][31:0] words;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] ch);
		hex_t       h;
		logic [7:0] diff;
		h = '0;
		diff = '0;
		if (ch >= CH_0 && ch <= CH_9) begin
			diff = ch - CH_0;
			h.valid = 1'b1;
			h.value = diff[3:0];
		end else if (ch >= CH_LA && ch <= CH_LF) begin
			diff = ch - CH_LA;
			h.valid = 1'b1;
			h.value = diff[3:0] + 4'd10;
		end else if (ch >= CH_UA && ch <= CH_UF) begin
			diff = ch - CH_UA;
			h.valid = 1'b1;
			h.value = diff[3:0] + 4'd10;
		end
		return h;
	endfunction

endpackage

FILE: rtl/guid_text_parser_unit.sv
// Top level of the GUID text parser: input register, parse state, result register.
// A taken character is held in the input register and parsed from there; for the last
// character the result is then registered in the output register (m_tvalid rises).
// Throughput: one character per cycle, with a combinational parse step; a last
// character waits in the input register only while the output register is full and not drained.
// Reset (arst_n low, asynchronous): both registers empty, parse state cleared,
// uuid_mode 0. The three finished-word registers are not reset.
`include "guid_text_parser_unit_defines.svh"

module guid_text_parser_unit import gtp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: uuid_mode
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	// character stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] character
	input  logic         s_tlast,   // last_char
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [31:0] word0, [63:32] word1, [95:64] word2, [127:96] word3
	output logic         m_tuser    // ok
);

	// mode register; the user must write it only while idle, the block does not enforce it
	logic uuid_mode_q;

	// input register stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// parse state and finished words 0..2
	parse_state_t     state_q;
	logic [2:0][31:0] words_q;

	// result register
	logic    out_valid_q;
	result_t out_q;

	parse_state_t state_nxt;
	word_wr_t     word_wr;
	result_t      res;

	logic out_free;
	logic s1_go;
	logic s1_fire;

	// Output slot frees when empty or drained this cycle. A non-last character
	// never needs it, so it moves through regardless of downstream stalls.
	assign out_free = !out_valid_q || m_tready;
	assign s1_go    = !last_s1 || out_free;
	assign s1_fire  = valid_s1 && s1_go;
	assign s_tready = !valid_s1 || s1_go;

	gtp_parse u_parse (
		.uuid_mode (uuid_mode_q),
		.character (char_s1),
		.last_char (last_s1),
		.cur       (state_q),
		.words     (words_q),
		.nxt       (state_nxt),
		.wr        (word_wr),
		.res       (res)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uuid_mode_q <= 1'b0;
			valid_s1    <= 1'b0;
			state_q     <= PARSE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				uuid_mode_q <= cfg_wdata;
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (s1_fire)
				state_q <= state_nxt;
			if (out_free)
				out_valid_q <= s1_fire && last_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (s1_fire && word_wr.en)
			words_q[word_wr.idx] <= state_q.accumulator;
		if (s1_fire && last_s1)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.words;
	assign m_tuser  = out_q.ok;

	// a failed string carries all-zero words
	`GTP_ASSERT_NOW(a_fail_zero, m_tvalid && !m_tuser, m_tdata == 128'd0, "failed result with nonzero words")
	// the last character of a string leaves the parse state cleared
	`GTP_ASSERT_NEXT(a_clear_after_last, s1_fire && last_s1, state_q == PARSE_RESET, "parse state not cleared after last character")
	// a UUID word never holds more than eight digits
	`GTP_ASSERT_NOW(a_digit_bound, 1'b1, state_q.digits_in_group <= WORD_DIGITS, "digit count beyond word size")

endmodule

FILE: rtl/gtp_parse.sv
// Per-character next-state and result logic of the GUID text parser.
module gtp_parse import gtp_pkg::*; (
	input  logic             uuid_mode,
	input  logic [7:0]       character,
	input  logic             last_char,
	input  parse_state_t     cur,
	input  logic [2:0][31:0] words,
	output parse_state_t     nxt,
	output word_wr_t         wr,
	output result_t          res
);

	always_comb begin
		hex_t         hx;
		logic         is_dash;
		logic         dash_pos;
		logic         ok;
		parse_state_t st;
		hx = hex_decode(character);
		is_dash = (character == CH_DASH);
		dash_pos = (cur.position == DASH_P0) || (cur.position == DASH_P1) ||
			(cur.position == DASH_P2) || (cur.position == DASH_P3);
		st = cur;
		wr = '0;
		ok = 1'b0;
		res = '0;

		if (!cur.failed) begin
			if (uuid_mode) begin
				if (cur.position >= UUID_LEN) begin
					st.failed = 1'b1;
				end else if (dash_pos) begin
					if (!is_dash)
						st.failed = 1'b1;
				end else if (!hx.valid) begin
					st.failed = 1'b1;
				end else if (cur.digits_in_group >= WORD_DIGITS) begin
					// word full: retire it and start the next with this digit
					if (cur.group_index < GROUP_LAST) begin
						wr.en = 1'b1;
						wr.idx = cur.group_index;
						st.group_index = cur.group_index + 2'd1;
					end
					st.accumulator = {28'd0, hx.value};
					st.digits_in_group = 4'd1;
				end else begin
					st.accumulator = {cur.accumulator[27:0], hx.value};
					st.digits_in_group = cur.digits_in_group + 4'd1;
				end
			end else begin
				if (is_dash) begin
					if (cur.group_empty || cur.group_index >= GROUP_LAST) begin
						st.failed = 1'b1;
					end else begin
						wr.en = 1'b1;
						wr.idx = cur.group_index;
						st.group_index = cur.group_index + 2'd1;
						st.accumulator = '0;
						st.group_empty = 1'b1;
					end
				end else if (!hx.valid) begin
					st.failed = 1'b1;
				end else if (cur.accumulator[31:28] != 4'd0) begin
					// another digit would overflow 32 bits
					st.failed = 1'b1;
				end else begin
					st.accumulator = {cur.accumulator[27:0], hx.value};
					st.group_empty = 1'b0;
				end
			end
		end

		if (!last_char) begin
			if (st.position != POS_MAX)
				st.position = st.position + 6'd1;
			nxt = st;
		end else begin
			if (uuid_mode)
				ok = !st.failed && (st.position == UUID_LAST) &&
					(st.group_index == GROUP_LAST) && (st.digits_in_group == WORD_DIGITS);
			else
				ok = !st.failed && (st.group_index == GROUP_LAST) && !st.group_empty;
			res.ok = ok;
			if (ok)
				res.words = {st.accumulator, words[2], words[1], words[0]};
			nxt = PARSE_RESET;
		end
	end

endmodule

FILE: sim/tb.sv
// Testbench for guid_text_parser_unit: random and directed GUID strings checked against a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gtp_pkg::*;

	typedef logic [7:0] char_t;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned PHASE_ITEMS  = 230;
	localparam int unsigned IDLE_PERCENT = 12;
	localparam int unsigned NUM_PHASES   = 8;
	localparam bit          PHASE_MODE [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1,
	                                                    1'b0, 1'b0, 1'b1, 1'b0};
	// characters just outside the hex and dash ranges
	localparam char_t NEAR_MISS [8] = '{8'h2f, 8'h3a, 8'h40, 8'h47,
	                                    8'h60, 8'h67, 8'h2c, 8'h2e};

	// Predicts the parse of each string and holds the results still owed by the block.
	class guid_parse_model;
		bit          uuid_mode;
		logic [5:0]  char_idx;
		logic [2:0]  words_done;
		word_t       acc;
		bit          group_blank;
		logic [3:0]  word_digits;
		bit          broken;
		word_t       done_words [3];
		result_t     pending_results [$];
		int unsigned errors;

		function new();
			uuid_mode = 1'b0;
			errors = 0;
			foreach (done_words[k]) done_words[k] = '0;
			restart();
		endfunction

		function void restart();
			char_idx = '0;
			words_done = '0;
			acc = '0;
			group_blank = 1'b1;
			word_digits = '0;
			broken = 1'b0;
		endfunction

		function bit hex_nibble(char_t ch, output logic [3:0] v);
			v = '0;
			if (ch >= CH_0 && ch <= CH_9) v = 4'(ch - CH_0);
			else if (ch >= CH_LA && ch <= CH_LF) v = 4'(ch - CH_LA + 8'd10);
			else if (ch >= CH_UA && ch <= CH_UF) v = 4'(ch - CH_UA + 8'd10);
			else return 1'b0;
			return 1'b1;
		endfunction

		function void dashed_char(char_t ch);
			logic [3:0] v;
			if (ch == CH_DASH) begin
				// dash closes a group; empty group or a fourth dash is an error
				if (group_blank || words_done >= 3) begin
					broken = 1'b1;
					return;
				end
				done_words[words_done[1:0]] = acc;
				words_done++;
				acc = '0;
				group_blank = 1'b1;
				return;
			end
			if (!hex_nibble(ch, v) || acc > 32'h0fff_ffff) begin
				broken = 1'b1;
				return;
			end
			acc = {acc[27:0], v};
			group_blank = 1'b0;
		endfunction

		function void uuid_char(char_t ch);
			logic [3:0] v;
			bit         on_dash;
			on_dash = char_idx == DASH_P0 || char_idx == DASH_P1 ||
			          char_idx == DASH_P2 || char_idx == DASH_P3;
			if (char_idx >= UUID_LEN) begin
				broken = 1'b1;
				return;
			end
			if (on_dash) begin
				if (ch != CH_DASH) broken = 1'b1;
				return;
			end
			if (!hex_nibble(ch, v)) begin
				broken = 1'b1;
				return;
			end
			if (word_digits >= WORD_DIGITS) begin
				if (words_done < 3) begin
					done_words[words_done[1:0]] = acc;
					words_done++;
				end
				acc = '0;
				word_digits = '0;
			end
			acc = {acc[27:0], v};
			word_digits++;
		endfunction

		// note one accepted character; a last character owes one result
		function void take_char(char_t ch, bit last);
			result_t r;
			bit      ok;
			if (!broken) begin
				if (uuid_mode) uuid_char(ch);
				else dashed_char(ch);
			end
			if (!last) begin
				if (char_idx != POS_MAX) char_idx++;
				return;
			end
			if (uuid_mode)
				ok = !broken && char_idx == UUID_LAST && words_done == 3 &&
				     word_digits == WORD_DIGITS;
			else
				ok = !broken && words_done == 3 && !group_blank;
			r.ok = ok;
			r.words = ok ? {acc, done_words[2], done_words[1], done_words[0]} : '0;
			pending_results.push_back(r);
			restart();
		endfunction

		task report(string what);
			errors++;
			if (errors <= 100) $display("mismatch %0d: %s", errors, what);
		endtask

		task check_parse_result(logic ok, logic [127:0] data);
			result_t e;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing owed, ok=%0b data=%h", ok, data));
				return;
			end
			e = pending_results.pop_front();
			if (ok !== e.ok)
				report($sformatf("ok got %0b want %0b", ok, e.ok));
			for (int k = 0; k < 4; k++)
				if (data[32*k +: 32] !== e.words[k])
					report($sformatf("word%0d got %h want %h", k, data[32*k +: 32],
					                 e.words[k]));
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         m_tuser;

	guid_parse_model board = new();
	char_t           guid_text [$];
	char_t           char_backlog [$];
	bit              calm = 1'b0;
	bit              hold_req = 1'b0;
	int unsigned     cycle_count;

	guid_text_parser_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic bit take_gap();
		return !calm && $urandom_range(99) < IDLE_PERCENT;
	endfunction

	function automatic char_t digit_char(logic [3:0] v);
		if (v < 4'd10) return CH_0 + char_t'(v);
		return ($urandom_range(1) ? CH_UA : CH_LA) + char_t'(v) - 8'd10;
	endfunction

	function automatic char_t noise_char();
		case ($urandom_range(6))
			0, 1, 2, 3: return char_t'($urandom_range(255));
			4: return NEAR_MISS[$urandom_range(7)];
			5: return digit_char(4'($urandom_range(15)));
			default: return CH_DASH;
		endcase
	endfunction

	// four groups; some with leading zeros, some all-F, a few nine digits long
	function automatic void build_dashed();
		int unsigned lead;
		int unsigned sig;
		int unsigned r;
		bit          all_f;
		for (int g = 0; g < 4; g++) begin
			if (g > 0) guid_text.push_back(CH_DASH);
			lead = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
			r = $urandom_range(99);
			sig = (r < 6) ? 9 : ((r < 12) ? 0 : $urandom_range(1, 8));
			if (lead + sig == 0) sig = 1;
			all_f = $urandom_range(19) == 0;
			repeat (lead) guid_text.push_back(CH_0);
			for (int i = 0; i < sig; i++)
				guid_text.push_back(digit_char(all_f ? 4'hf :
					4'((i == 0) ? $urandom_range(1, 15) : $urandom_range(15))));
		end
	endfunction

	function automatic void build_uuid();
		for (int p = 0; p < 36; p++)
			if (p == DASH_P0 || p == DASH_P1 || p == DASH_P2 || p == DASH_P3)
				guid_text.push_back(CH_DASH);
			else
				guid_text.push_back(digit_char(4'($urandom_range(15))));
	endfunction

	// break a well-formed string in one spot
	function automatic void mangle_text();
		int unsigned at;
		at = $urandom_range(guid_text.size() - 1);
		case ($urandom_range(5))
			0: guid_text[at] = noise_char();
			1: guid_text[at] = CH_DASH;
			2: if (guid_text.size() > 1) guid_text.delete(at);
			3: guid_text.insert(at, $urandom_range(1) ? CH_DASH : noise_char());
			4: guid_text = guid_text[0:at];
			// long tail also runs the index past its saturation point
			default: repeat ($urandom_range(1, 30))
				guid_text.push_back(digit_char(4'($urandom_range(15))));
		endcase
	endfunction

	function automatic void build_string();
		bit native;
		guid_text.delete();
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 6)) guid_text.push_back(noise_char());
		end else begin
			native = $urandom_range(99) < 85;
			if (board.uuid_mode == native) build_uuid();
			else build_dashed();
			if ($urandom_range(99) < 30) mangle_text();
		end
		foreach (guid_text[i]) char_backlog.push_back(guid_text[i]);
	endfunction

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++) char_backlog.push_back(s[i]);
	endfunction

	task automatic send_char(input char_t ch, input bit last);
		while (take_gap()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.take_char(ch, last);
	endtask

	task automatic send_next();
		bit    last;
		char_t ch;
		last = char_backlog.size() == 1;
		ch = char_backlog.pop_front();
		send_char(ch, last);
	endtask

	// a phase may stop mid-string; the rest goes out after the next mode write
	task automatic run_phase(int unsigned n_items);
		for (int unsigned i = 0; i < n_items; i++) begin
			if (char_backlog.size() == 0) build_string();
			send_next();
		end
	endtask

	task automatic flush_backlog();
		while (char_backlog.size() != 0) send_next();
	endtask

	// all results in, then wait out a character still in the input register
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.uuid_mode = m;
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		// dashed form: digit extremes 0, 9, f and A, empty first group, out-of-range bytes,
		// too few dashes, empty last group
		queue_text("0-f-A-9");
		flush_backlog();
		queue_text("-");
		flush_backlog();
		char_backlog.push_back(8'h00);
		flush_backlog();
		char_backlog.push_back(8'hff);
		flush_backlog();
		queue_text("a-b-c");
		flush_backlog();
		queue_text("1-2-3-");
		flush_backlog();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			write_mode(PHASE_MODE[ph]);
			calm = ph == 1;
			if (ph == 2) hold_req = 1'b1;
			run_phase(PHASE_ITEMS);
		end
		flush_backlog();
		s_tvalid <= 1'b0;

		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("[guid_text_parser_unit] OK");
		else
			$display("[guid_text_parser_unit] ERROR");
		$finish;
	end

	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_parse_result(m_tuser, m_tdata);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !take_gap();
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[guid_text_parser_unit] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/gtp_pkg.sv
rtl/gtp_parse.sv
rtl/guid_text_parser_unit.sv
sim/tb.sv
